// ===== rtl/nfaea_pkg.sv =====
package nfaea_pkg;

	localparam int NUM_STATES  = 16;
	localparam int MAX_EDGES   = 8;
	localparam int SYMBOL_BITS = 8;

	localparam int ST_W   = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int SL_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int DEST_W = 4;

	localparam int SPACE_CODE = 32;
	localparam bit SPACE_OK   = (SPACE_CODE <= ((2 ** SYMBOL_BITS) - 1));

	typedef enum logic [2:0] {
		K_EDGE  = 3'd0,
		K_EMPTY = 3'd1,
		K_ACC   = 3'd2,
		K_SYM   = 3'd3,
		K_END   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_CLOSE,
		SQ_ADV,
		SQ_FIN
	} seq_state_t;

	// table write request
	typedef struct packed {
		logic                   we_edge;
		logic                   we_empty;
		logic                   we_acc;
		logic [ST_W-1:0]        row;
		logic [SL_W-1:0]        slot;
		logic [SYMBOL_BITS-1:0] label;
		logic [DEST_W-1:0]      dest;
		logic                   en;
	} tbl_wr_t;

	// one state's row of both edge tables
	typedef struct packed {
		logic [MAX_EDGES-1:0][SYMBOL_BITS-1:0] label;
		logic [MAX_EDGES-1:0][DEST_W-1:0]      edest;
		logic [MAX_EDGES-1:0]                  evld;
		logic [MAX_EDGES-1:0][DEST_W-1:0]      mdest;
		logic [MAX_EDGES-1:0]                  mvld;
	} tbl_row_t;

	typedef struct packed {
		logic busy;
		logic res_vld;
		logic res_acc;
	} seq_stat_t;

	function automatic logic [NUM_STATES-1:0] sbit(input logic [DEST_W-1:0] d);
		logic [NUM_STATES-1:0] b;
		b = '0;
		if (int'(d) < NUM_STATES) b[d] = 1'b1;
		return b;
	endfunction

endpackage

// ===== rtl/nfaea_ram.sv =====
module nfaea_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end
endmodule

// ===== rtl/nfaea_tables.sv =====
module nfaea_tables (
	input  logic                       clk,
	input  logic                       arst_n,
	input  nfaea_pkg::tbl_wr_t         wr,
	input  logic                       rd_en,
	input  logic [nfaea_pkg::ST_W-1:0] rd_row,
	output nfaea_pkg::tbl_row_t        row,
	output logic [nfaea_pkg::NUM_STATES-1:0] acc
);
	import nfaea_pkg::*;

	logic [NUM_STATES-1:0][MAX_EDGES-1:0] evld_q;
	logic [NUM_STATES-1:0][MAX_EDGES-1:0] mvld_q;
	logic [MAX_EDGES-1:0]                 evld_rd_q;
	logic [MAX_EDGES-1:0]                 mvld_rd_q;
	logic [NUM_STATES-1:0]                acc_q;

	for (genvar k = 0; k < MAX_EDGES; k++) begin : g_slot
		logic ewe, mwe;
		assign ewe = wr.we_edge && (wr.slot == SL_W'(k));
		assign mwe = wr.we_empty && (wr.slot == SL_W'(k));

		nfaea_ram #(.WIDTH(SYMBOL_BITS + DEST_W), .DEPTH(NUM_STATES)) u_edge (
			.clk   (clk),
			.we    (ewe),
			.waddr (wr.row),
			.wdata ({wr.label, wr.dest}),
			.re    (rd_en),
			.raddr (rd_row),
			.rdata ({row.label[k], row.edest[k]})
		);

		nfaea_ram #(.WIDTH(DEST_W), .DEPTH(NUM_STATES)) u_empty (
			.clk   (clk),
			.we    (mwe),
			.waddr (wr.row),
			.wdata (wr.dest),
			.re    (rd_en),
			.raddr (rd_row),
			.rdata (row.mdest[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evld_q <= '0;
			mvld_q <= '0;
			acc_q  <= '0;
		end else begin
			if (wr.we_edge)  evld_q[wr.row][wr.slot] <= wr.en;
			if (wr.we_empty) mvld_q[wr.row][wr.slot] <= wr.en;
			if (wr.we_acc)   acc_q[wr.row] <= wr.en;
		end
	end

	// valid bits follow the RAM read latency
	always_ff @(posedge clk) begin
		if (rd_en) begin
			evld_rd_q <= evld_q[rd_row];
			mvld_rd_q <= mvld_q[rd_row];
		end
	end

	assign row.evld = evld_rd_q;
	assign row.mvld = mvld_rd_q;
	assign acc      = acc_q;
endmodule

// ===== rtl/nfaea_seq.sv =====
module nfaea_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              start_end,
	input  logic [nfaea_pkg::SYMBOL_BITS-1:0] start_sym,
	input  logic                              res_ok,
	input  nfaea_pkg::tbl_row_t               row,
	input  logic [nfaea_pkg::NUM_STATES-1:0]  acc,
	output logic                              rd_en,
	output logic [nfaea_pkg::ST_W-1:0]        rd_row,
	output nfaea_pkg::seq_stat_t              stat
);
	import nfaea_pkg::*;

	seq_state_t             state_q, state_d;
	logic [ST_W:0]          cnt_q, cnt_d;
	logic                   vld_s1;
	logic [ST_W-1:0]        row_s1;
	logic [NUM_STATES-1:0]  set_q, set_d;
	logic [NUM_STATES-1:0]  nxt_q, nxt_d;
	logic                   grew_q, grew_d;
	logic                   post_q, post_d;
	logic                   end_q, end_d;
	logic [SYMBOL_BITS-1:0] sym_q, sym_d;
	logic                   start_q, start_d;
	logic                   latch_q, latch_d;
	logic                   hit_q, hit_d;
	logic [NUM_STATES-1:0]  clos_add, adv_add, set_new;
	logic                   live, last;

	assign live = vld_s1 && set_q[row_s1];
	assign last = (cnt_q == (ST_W+1)'(NUM_STATES));

	always_comb begin
		clos_add = '0;
		adv_add  = '0;
		for (int k = 0; k < MAX_EDGES; k++) begin
			if (live && row.mvld[k]) clos_add = clos_add | sbit(row.mdest[k]);
			if (live && row.evld[k] && (row.label[k] == sym_q))
				adv_add = adv_add | sbit(row.edest[k]);
		end
	end

	assign set_new = set_q | clos_add;
	assign rd_en   = ((state_q == SQ_CLOSE) || (state_q == SQ_ADV)) && !last;
	assign rd_row  = cnt_q[ST_W-1:0];

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		set_d   = set_q;
		nxt_d   = nxt_q;
		grew_d  = grew_q;
		post_d  = post_q;
		end_d   = end_q;
		sym_d   = sym_q;
		start_d = start_q;
		latch_d = latch_q;
		hit_d   = hit_q;
		stat    = '{busy: (state_q != SQ_IDLE), res_vld: 1'b0,
		            res_acc: (|(set_q & acc)) || hit_q};
		if (rd_en) cnt_d = cnt_q + 1'b1;
		case (state_q)
			SQ_IDLE: begin
				if (start) begin
					end_d = start_end;
					sym_d = start_sym;
					cnt_d = '0;
					grew_d = 1'b0;
					nxt_d = '0;
					if (start_q) begin
						set_d   = sbit(DEST_W'(0));
						post_d  = 1'b0;
						state_d = SQ_CLOSE;
					end else if (start_end) begin
						state_d = SQ_FIN;
					end else begin
						state_d = SQ_ADV;
					end
				end
			end
			SQ_CLOSE: begin
				set_d = set_new;
				if (set_new != set_q) grew_d = 1'b1;
				if (last) begin
					cnt_d  = '0;
					grew_d = 1'b0;
					if (!(grew_q || (set_new != set_q))) begin
						if (post_q) begin
							if (latch_q && (|(set_new & acc))) hit_d = 1'b1;
							state_d = SQ_IDLE;
						end else if (end_q) begin
							state_d = SQ_FIN;
						end else begin
							// first symbol of the word
							start_d = 1'b0;
							latch_d = SPACE_OK && (sym_q == SYMBOL_BITS'(SPACE_CODE));
							hit_d   = SPACE_OK && (sym_q == SYMBOL_BITS'(SPACE_CODE))
							          && (|(set_new & acc));
							nxt_d   = '0;
							state_d = SQ_ADV;
						end
					end
				end
			end
			SQ_ADV: begin
				nxt_d = nxt_q | adv_add;
				if (last) begin
					set_d   = nxt_q | adv_add;
					cnt_d   = '0;
					grew_d  = 1'b0;
					post_d  = 1'b1;
					state_d = SQ_CLOSE;
				end
			end
			SQ_FIN: begin
				if (res_ok) begin
					stat.res_vld = 1'b1;
					start_d = 1'b1;
					latch_d = 1'b0;
					hit_d   = 1'b0;
					state_d = SQ_IDLE;
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			grew_q  <= 1'b0;
			post_q  <= 1'b0;
			end_q   <= 1'b0;
			start_q <= 1'b1;
			latch_q <= 1'b0;
			hit_q   <= 1'b0;
			set_q   <= '0;
			nxt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			vld_s1  <= rd_en;
			grew_q  <= grew_d;
			post_q  <= post_d;
			end_q   <= end_d;
			start_q <= start_d;
			latch_q <= latch_d;
			hit_q   <= hit_d;
			set_q   <= set_d;
			nxt_q   <= nxt_d;
		end
	end

	always_ff @(posedge clk) begin
		row_s1 <= rd_row;
		sym_q  <= sym_d;
	end
endmodule

// ===== rtl/nfa_epsilon_word_acceptor.sv =====
// Word acceptor for a nondeterministic automaton with empty moves.
// Input channel (in_valid/in_ready) carries one item per transaction:
//   kinds 0..2 load the symbol edge table, empty edge table and accepting
//   flags; kind 3 feeds one word symbol; kind 4 ends the word. Kinds 5..7
//   are dropped. Out-of-range table indexes are dropped.
// Output channel (out_valid/out_ready) carries one 'accepted' bit per
//   end-of-word transaction, and nothing for other kinds.
// Tables live in per-slot RAMs with one row per state, so one state's
//   edges come out in one read; every walk over the states is a sweep
//   that reads each state's row once (registered read).
// Work per item kind:
//   table writes: written when taken, next item accepted the following cycle.
//   word symbol: one sweep for the edge walk plus P closure passes
//     (P = 1..NUM_STATES, number of passes until the set stops growing).
//     The first symbol of a word adds a closure of state 0 up front.
//   end of word: the final step, plus, at word start, a closure of state 0.
// The block takes one item at a time; in_ready is low while it works.
// Reset clears valid bits and accepting flags; no clearing pass.
// A stalled receiver holds the result in the output register; a following
//   end of word waits in its last step until that register frees up.
module nfa_epsilon_word_acceptor (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] kind,
	input  logic [3:0] state_index,
	input  logic [2:0] slot_index,
	input  logic [7:0] symbol,
	input  logic [3:0] target_state,
	input  logic       enable,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       accepted
);
	import nfaea_pkg::*;

	tbl_wr_t               wr;
	tbl_row_t              row;
	seq_stat_t             stat;
	logic [NUM_STATES-1:0] acc;
	logic                  rd_en;
	logic [ST_W-1:0]       rd_row;
	logic                  take, st_ok, sl_ok, res_ok;
	logic                  out_valid_q, accepted_q;

	assign in_ready = !stat.busy;
	assign take     = in_valid && in_ready;
	assign st_ok    = int'(state_index) < NUM_STATES;
	assign sl_ok    = int'(slot_index) < MAX_EDGES;

	always_comb begin
		wr          = '0;
		wr.row      = ST_W'(state_index);
		wr.slot     = SL_W'(slot_index);
		wr.label    = SYMBOL_BITS'(symbol);
		wr.dest     = target_state;
		wr.en       = enable;
		wr.we_edge  = take && (kind == K_EDGE) && st_ok && sl_ok;
		wr.we_empty = take && (kind == K_EMPTY) && st_ok && sl_ok;
		wr.we_acc   = take && (kind == K_ACC) && st_ok;
	end

	nfaea_tables u_tables (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd_en  (rd_en),
		.rd_row (rd_row),
		.row    (row),
		.acc    (acc)
	);

	assign res_ok = !out_valid_q || out_ready;

	nfaea_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (take && ((kind == K_SYM) || (kind == K_END))),
		.start_end (kind == K_END),
		.start_sym (SYMBOL_BITS'(symbol)),
		.res_ok    (res_ok),
		.row       (row),
		.acc       (acc),
		.rd_en     (rd_en),
		.rd_row    (rd_row),
		.stat      (stat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.res_vld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.res_vld) accepted_q <= stat.res_acc;
	end

	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;
endmodule

// ===== rtl/nfaea_checker.sv =====
module nfaea_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [2:0] kind,
	input logic       out_valid,
	input logic       out_ready,
	input logic       accepted
);
	import nfaea_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(accepted))
		else $error("result changed under stall");

	// a word symbol keeps the block busy in the cycle after it is taken
	a_sym_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == K_SYM) |=> !in_ready)
		else $error("symbol finished too early");

	// a table write leaves the input ready in the next cycle
	a_wr_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == K_EDGE || kind == K_EMPTY || kind == K_ACC)
		|=> in_ready)
		else $error("table write stalled input");

	// a symbol never produces a result on the next edge
	a_sym_nores: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == K_SYM) && !out_valid |=> !out_valid)
		else $error("result from word symbol");
endmodule

bind nfa_epsilon_word_acceptor nfaea_checker u_nfaea_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.kind      (kind),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.accepted  (accepted)
);

// ===== test/nfa_word_checker.sv =====
`timescale 1ns / 1ps
module nfa_word_checker
	import nfaea_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [2:0] kind,
	input  logic [3:0] state_index,
	input  logic [2:0] slot_index,
	input  logic [7:0] symbol,
	input  logic [3:0] target_state,
	input  logic       enable,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       accepted,
	output int         fail_count,
	output int         pending_verdicts,
	output int         verdicts_seen
);
	// shadow tables
	logic [7:0]            lbl_mem  [NUM_STATES][MAX_EDGES];
	logic [3:0]            ldst_mem [NUM_STATES][MAX_EDGES];
	logic                  lvld_mem [NUM_STATES][MAX_EDGES];
	logic [3:0]            edst_mem [NUM_STATES][MAX_EDGES];
	logic                  evld_mem [NUM_STATES][MAX_EDGES];
	logic [NUM_STATES-1:0] acc_flags;
	logic [NUM_STATES-1:0] live_set;
	bit                    word_fresh;
	bit                    lead_space;
	bit                    hit_seen;
	bit                    verdict_q[$];

	assign pending_verdicts = verdict_q.size();

	function automatic logic [NUM_STATES-1:0] onehot(input logic [3:0] d);
		logic [NUM_STATES-1:0] r;
		r = '0;
		if (int'(d) < NUM_STATES) r[d] = 1'b1;
		return r;
	endfunction

	function automatic logic [NUM_STATES-1:0] eclose(input logic [NUM_STATES-1:0] s);
		logic [NUM_STATES-1:0] cur;
		logic [NUM_STATES-1:0] prev;
		cur = s;
		do begin
			prev = cur;
			for (int i = 0; i < NUM_STATES; i++)
				if (cur[i])
					for (int k = 0; k < MAX_EDGES; k++)
						if (evld_mem[i][k]) cur |= onehot(edst_mem[i][k]);
		end while (cur != prev);
		return cur;
	endfunction

	function automatic logic [NUM_STATES-1:0] step_set(input logic [NUM_STATES-1:0] s,
			input logic [7:0] c);
		logic [NUM_STATES-1:0] n;
		n = '0;
		for (int i = 0; i < NUM_STATES; i++)
			if (s[i])
				for (int k = 0; k < MAX_EDGES; k++)
					if (lvld_mem[i][k] && lbl_mem[i][k] == c) n |= onehot(ldst_mem[i][k]);
		return eclose(n);
	endfunction

	task automatic open_word_if_fresh();
		if (word_fresh) begin
			live_set   = eclose(onehot(4'd0));
			lead_space = 0;
			hit_seen   = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STATES; i++)
				for (int k = 0; k < MAX_EDGES; k++) begin
					lvld_mem[i][k] = 0;
					evld_mem[i][k] = 0;
					lbl_mem[i][k]  = '0;
					ldst_mem[i][k] = '0;
					edst_mem[i][k] = '0;
				end
			acc_flags  = '0;
			live_set   = 16'h1;
			word_fresh = 1;
			lead_space = 0;
			hit_seen   = 0;
			verdict_q.delete();
			fail_count    = 0;
			verdicts_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				verdicts_seen++;
				if (verdict_q.size() == 0) begin
					$error("accepted: unexpected result %0b", accepted);
					fail_count++;
				end else begin
					bit want;
					want = verdict_q.pop_front();
					if (accepted !== want) begin
						$error("accepted: expected %0b actual %0b", want, accepted);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				case (kind)
					K_EDGE: begin
						lbl_mem[state_index][slot_index]  = symbol;
						ldst_mem[state_index][slot_index] = target_state;
						lvld_mem[state_index][slot_index] = enable;
					end
					K_EMPTY: begin
						edst_mem[state_index][slot_index] = target_state;
						evld_mem[state_index][slot_index] = enable;
					end
					K_ACC: acc_flags[state_index] = enable;
					K_SYM: begin
						open_word_if_fresh();
						if (word_fresh) begin
							lead_space = SPACE_OK && (symbol == SPACE_CODE[7:0]);
							word_fresh = 0;
							if (lead_space && |(live_set & acc_flags)) hit_seen = 1;
						end
						live_set = step_set(live_set, symbol);
						if (lead_space && |(live_set & acc_flags)) hit_seen = 1;
					end
					K_END: begin
						open_word_if_fresh();
						verdict_q.push_back(|(live_set & acc_flags) || hit_seen);
						word_fresh = 1;
						lead_space = 0;
						hit_seen   = 0;
					end
					default: ;
				endcase
			end
		end
	end
endmodule

// ===== test/tb_nfa_epsilon_word_acceptor.sv =====
`timescale 1ns / 1ps
module tb_nfa_epsilon_word_acceptor;
	import nfaea_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] kind;
	logic [3:0] state_index;
	logic [2:0] slot_index;
	logic [7:0] symbol;
	logic [3:0] target_state;
	logic       enable;
	logic       out_valid;
	logic       out_ready;
	logic       accepted;
	int         fail_count;
	int         pending_verdicts;
	int         verdicts_seen;
	int         items_sent;

	nfa_epsilon_word_acceptor uut (.*);

	// checker sits beside the DUT and watches both channels
	nfa_word_checker chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// watchdog: reports a FAIL and stops the run if it does not finish in time
	initial begin
		#(12 * 6000000);
		$display("Regression FAIL");
		$finish;
	end

	// receiver: random stall per transaction, bursts of always-ready too
	initial begin
		int gap;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			repeat (gap) @(posedge clk);
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			out_ready <= 0;
		end
	end

	// one transaction; sender gap drawn per item
	task automatic send_item(input kind_t k, input logic [3:0] st, input logic [2:0] sl,
			input logic [7:0] sy, input logic [3:0] ds, input logic en, input bit burst);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 13);
		repeat (gap) @(posedge clk);
		in_valid     <= 1;
		kind         <= k;
		state_index  <= st;
		slot_index   <= sl;
		symbol       <= sy;
		target_state <= ds;
		enable       <= en;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		in_valid <= 0;
		items_sent++;
	endtask

	task automatic send_raw(input logic [2:0] k);
		send_item(kind_t'(k), 4'($urandom), 3'($urandom), 8'($urandom), 4'($urandom),
			1'($urandom), 1'b0);
	endtask

	// random automaton over a small alphabet so words actually move through it
	task automatic load_random_nfa(input int nedges, input bit burst);
		for (int i = 0; i < nedges; i++) begin
			int r;
			r = $urandom_range(0, 9);
			if (r < 5)
				send_item(K_EDGE, 4'($urandom), 3'($urandom),
					($urandom_range(0, 7) == 0) ? 8'd32 : 8'(97 + $urandom_range(0, 2)),
					4'($urandom), $urandom_range(0, 5) != 0, burst);
			else if (r < 8)
				send_item(K_EMPTY, 4'($urandom), 3'($urandom), 8'($urandom), 4'($urandom),
					$urandom_range(0, 2) != 0, burst);
			else
				send_item(K_ACC, 4'($urandom), 3'($urandom), 8'($urandom), 4'($urandom),
					1'($urandom), burst);
		end
	endtask

	task automatic send_word(input int len, input bit burst);
		for (int i = 0; i < len; i++) begin
			logic [7:0] c;
			c = ($urandom_range(0, 5) == 0) ? 8'd32 : 8'(97 + $urandom_range(0, 2));
			if ($urandom_range(0, 15) == 0) c = 8'($urandom);
			send_item(K_SYM, 4'($urandom), 3'($urandom), c, 4'($urandom), 1'($urandom),
				burst);
			if ($urandom_range(0, 30) == 0) load_random_nfa(1, burst);
		end
		send_item(K_END, 4'($urandom), 3'($urandom), 8'($urandom), 4'($urandom),
			1'($urandom), burst);
	endtask

	initial begin
		bit burst;
		items_sent   = 0;
		in_valid     = 0;
		kind         = '0;
		state_index  = '0;
		slot_index   = '0;
		symbol       = '0;
		target_state = '0;
		enable       = 0;
		arst_n       = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty word on empty tables, extremes, empty-move loop, leading space
		send_item(K_END, 4'd0, 3'd0, 8'd0, 4'd0, 1'b0, 1'b0);
		send_item(K_ACC, 4'd0, 3'd0, 8'd0, 4'd0, 1'b1, 1'b0);
		send_item(K_END, 4'd15, 3'd7, 8'd255, 4'd15, 1'b1, 1'b0);
		send_item(K_ACC, 4'd0, 3'd7, 8'd255, 4'd15, 1'b0, 1'b0);
		send_item(K_EMPTY, 4'd0, 3'd0, 8'd0, 4'd15, 1'b1, 1'b0);
		send_item(K_EMPTY, 4'd15, 3'd7, 8'd0, 4'd0, 1'b1, 1'b0);
		send_item(K_ACC, 4'd15, 3'd0, 8'd0, 4'd0, 1'b1, 1'b0);
		send_item(K_END, 4'd0, 3'd0, 8'd0, 4'd0, 1'b0, 1'b0);
		send_item(K_EDGE, 4'd15, 3'd7, 8'd255, 4'd3, 1'b1, 1'b0);
		send_item(K_EDGE, 4'd0, 3'd0, 8'd32, 4'd5, 1'b1, 1'b0);
		send_item(K_EDGE, 4'd5, 3'd1, 8'd120, 4'd6, 1'b1, 1'b0);
		send_item(K_ACC, 4'd5, 3'd0, 8'd0, 4'd0, 1'b1, 1'b0);
		send_item(K_ACC, 4'd15, 3'd0, 8'd0, 4'd0, 1'b0, 1'b0);
		// leading space reaches accepting state 5 then leaves it
		send_item(K_SYM, 4'd0, 3'd0, 8'd32, 4'd0, 1'b0, 1'b0);
		send_item(K_SYM, 4'd0, 3'd0, 8'd120, 4'd0, 1'b0, 1'b0);
		send_item(K_END, 4'd0, 3'd0, 8'd0, 4'd0, 1'b0, 1'b0);
		send_item(K_SYM, 4'd0, 3'd0, 8'd255, 4'd0, 1'b0, 1'b0);
		send_item(K_END, 4'd0, 3'd0, 8'd0, 4'd0, 1'b0, 1'b0);
		send_raw(3'd5);
		send_raw(3'd7);
		send_item(K_EMPTY, 4'd0, 3'd0, 8'd0, 4'd0, 1'b0, 1'b0);
		send_item(K_EDGE, 4'd0, 3'd0, 8'd0, 4'd0, 1'b0, 1'b0);

		// pause until every verdict has drained
		while (pending_verdicts != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		while (items_sent < 1900) begin
			burst = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 5) == 0) load_random_nfa($urandom_range(4, 24), burst);
			case ($urandom_range(0, 9))
				0: send_raw(3'($urandom_range(5, 7)));
				1: send_raw(3'($urandom));
				default: send_word($urandom_range(0, 6), burst);
			endcase
		end

		while (pending_verdicts != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("Covered %0d input transactions and %0d word verdicts,", items_sent,
			verdicts_seen);
		$display("including empty-move cycles, leading-space words and ignored kinds.");
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
